FILE: design/complex_arithmetic_unit_core_defines.svh
// Assertion macros for the complex arithmetic unit core.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CAU_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(lbl, ante, cons)
`define CAU_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

FILE: design/cau_pkg.sv
// Package: widths, command codes, cell types and saturation for the complex arithmetic unit.
`default_nettype none
package cau_pkg;
  localparam int DW = 16;
  localparam int FB = 8;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;
  localparam int MW = 2 * DW;
  localparam int QW = DW + 1;
  localparam int NW = MW + FB;
  localparam int TW = QW + 1;
  localparam int VW = 2 * QW;
  localparam int NSTEP = QW;
  localparam int LAT = NSTEP + 4;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] DMAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN_V = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_NEG  = 3'd5,
    CMD_MAG  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ov;
  } sat_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [DW-1:0] rr;
    logic [DW-1:0] ri;
    logic          ov;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          pov_re;
    logic          pov_im;
  } tag_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] nb;
    logic [QW-1:0] q;
  } div_lane_t;

  typedef struct packed {
    logic [TW-1:0] rem;
    logic [VW-1:0] rad;
    logic [QW-1:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    tag_t          tag;
    logic [MW-1:0] den;
    div_lane_t     dre;
    div_lane_t     dim;
    sqrt_lane_t    sq;
  } cell_t;

  function automatic sat_t sat_fn(input logic signed [SW-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s.val = DMAX_V;
      s.ov  = 1'b1;
    end else if (v < SAT_LO) begin
      s.val = DMIN_V;
      s.ov  = 1'b1;
    end else begin
      s.val = v[DW-1:0];
      s.ov  = 1'b0;
    end
    return s;
  endfunction
endpackage
`default_nettype wire

FILE: design/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, divide/root cell chain, result stage.
// One transaction is taken in every clock cycle; busy never rises. Each result appears
// on the out_ ports for one cycle with out_valid high, in order. Each transaction passes
// through three front stages (operand register, products, sums), a chain of 17 cells
// that each resolve one quotient bit of both divide parts and one bit of the square root,
// and the output register. Results cannot be held off.
`default_nettype none
`include "complex_arithmetic_unit_core_defines.svh"
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_command,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_r_re,
  output logic signed [DW-1:0] out_r_im,
  output logic                 out_div_zero,
  output logic                 out_overflow
);
  logic          vld_chain [0:NSTEP];
  cell_t         cell_chain [0:NSTEP];
  cell_t         last;
  logic          out_valid_r;
  logic [DW-1:0] out_r_re_r, out_r_im_r, out_r_re_nxt, out_r_im_nxt;
  logic          out_dz_r, out_ov_r, out_dz_nxt, out_ov_nxt;
  sat_t          qre, qim;

  assign busy = 1'b0;

  cau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start && !busy),
    .in_command (in_command),
    .in_a_re    (in_a_re),
    .in_a_im    (in_a_im),
    .in_b_re    (in_b_re),
    .in_b_im    (in_b_im),
    .out_vld    (vld_chain[0]),
    .out_cell   (cell_chain[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    cau_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld_chain[g]),
      .in_cell  (cell_chain[g]),
      .out_vld  (vld_chain[g+1]),
      .out_cell (cell_chain[g+1])
    );
  end

  function automatic sat_t div_res(input logic neg, input logic pov, input logic [QW-1:0] q);
    sat_t          s;
    logic [QW-1:0] lim;
    lim = neg ? QW'(DMIN_V) : QW'(DMAX_V);
    if (pov || (q > lim)) begin
      s.val = neg ? DMIN_V : DMAX_V;
      s.ov  = 1'b1;
    end else begin
      s.val = neg ? DW'(QW'(0) - q) : q[DW-1:0];
      s.ov  = 1'b0;
    end
    return s;
  endfunction

  always_comb begin
    last         = cell_chain[NSTEP];
    qre          = div_res(last.tag.neg_re, last.tag.pov_re, last.dre.q);
    qim          = div_res(last.tag.neg_im, last.tag.pov_im, last.dim.q);
    out_r_re_nxt = last.tag.rr;
    out_r_im_nxt = last.tag.ri;
    out_dz_nxt   = 1'b0;
    out_ov_nxt   = last.tag.ov;
    case (last.tag.cmd)
      CMD_DIV: begin
        if (last.tag.dz) begin
          out_r_re_nxt = '0;
          out_r_im_nxt = '0;
          out_dz_nxt   = 1'b1;
          out_ov_nxt   = 1'b0;
        end else begin
          out_r_re_nxt = qre.val;
          out_r_im_nxt = qim.val;
          out_ov_nxt   = qre.ov | qim.ov;
        end
      end
      CMD_MAG: begin
        out_r_im_nxt = '0;
        if (last.sq.root > QW'(DMAX_V)) begin
          out_r_re_nxt = DMAX_V;
          out_ov_nxt   = 1'b1;
        end else begin
          out_r_re_nxt = last.sq.root[DW-1:0];
          out_ov_nxt   = 1'b0;
        end
      end
      default: begin
        out_dz_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_chain[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    out_r_re_r <= out_r_re_nxt;
    out_r_im_r <= out_r_im_nxt;
    out_dz_r   <= out_dz_nxt;
    out_ov_r   <= out_ov_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_r_re     = out_r_re_r;
  assign out_r_im     = out_r_im_r;
  assign out_div_zero = out_dz_r;
  assign out_overflow = out_ov_r;

  `CAU_ASSERT_DLY(a_latency, start && !busy, LAT, out_valid)
  `CAU_ASSERT_IMP(a_no_orphan, out_valid, $past(start && !busy, LAT))
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_div_zero, !out_overflow && out_r_re == 0 && out_r_im == 0)
endmodule
`default_nettype wire

FILE: design/cau_cell.sv
// One cell of the divide/square-root chain: one quotient bit per lane and one root bit.
`default_nettype none
module cau_cell import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  cell_t in_cell,
  output logic  out_vld,
  output cell_t out_cell
);
  logic  vld_r;
  cell_t cell_r;
  cell_t cell_nxt;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [MW-1:0] den);
    div_lane_t     o;
    logic [MW:0]   r2;
    r2 = {l.rem, l.nb[QW-1]};
    o.nb = {l.nb[QW-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = MW'(r2 - {1'b0, den});
      o.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      o.rem = r2[MW-1:0];
      o.q   = {l.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t s);
    sqrt_lane_t    o;
    logic [TW+1:0] rp;
    logic [TW+1:0] trial;
    rp    = {s.rem, s.rad[VW-1:VW-2]};
    trial = (TW+2)'({s.root, 2'b01});
    o.rad = {s.rad[VW-3:0], 2'b00};
    if (rp >= trial) begin
      o.rem  = TW'(rp - trial);
      o.root = {s.root[QW-2:0], 1'b1};
    end else begin
      o.rem  = TW'(rp);
      o.root = {s.root[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    cell_nxt     = in_cell;
    cell_nxt.dre = div_step(in_cell.dre, in_cell.den);
    cell_nxt.dim = div_step(in_cell.dim, in_cell.den);
    cell_nxt.sq  = sqrt_step(in_cell.sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;
endmodule
`default_nettype wire

FILE: design/cau_front.sv
// Front end: operand register, products, sums and setup of the divide/root chain.
`default_nettype none
module cau_front import cau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [2:0]           in_command,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output logic                 out_vld,
  output cell_t                out_cell
);
  logic                 s1_vld_r, s2_vld_r, s3_vld_r;
  cmd_t                 s1_cmd_r, s2_cmd_r;
  logic signed [DW-1:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic signed [DW-1:0] s2_a_r, s2_b_r, s2_c_r, s2_d_r;
  logic signed [PW-1:0] ac_r, bd_r, ad_r, bc_r, cc_r, dd_r, aa_r, bb_r;
  cell_t                cell_r;
  cell_t                cell_nxt;

  logic signed [SW-1:0] ea, eb, ec, ed, mre, mim, nre, nim;
  logic [MW-1:0]        den, sq, mag_re, mag_im;
  logic [NW-1:0]        n_re, n_im;
  sat_t                 sr, si;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= cmd_t'(in_command);
    s1_a_r   <= in_a_re;
    s1_b_r   <= in_a_im;
    s1_c_r   <= in_b_re;
    s1_d_r   <= in_b_im;
    s2_cmd_r <= s1_cmd_r;
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
    s2_c_r   <= s1_c_r;
    s2_d_r   <= s1_d_r;
    ac_r     <= s1_a_r * s1_c_r;
    bd_r     <= s1_b_r * s1_d_r;
    ad_r     <= s1_a_r * s1_d_r;
    bc_r     <= s1_b_r * s1_c_r;
    cc_r     <= s1_c_r * s1_c_r;
    dd_r     <= s1_d_r * s1_d_r;
    aa_r     <= s1_a_r * s1_a_r;
    bb_r     <= s1_b_r * s1_b_r;
    cell_r   <= cell_nxt;
  end

  always_comb begin
    ea     = SW'(s2_a_r);
    eb     = SW'(s2_b_r);
    ec     = SW'(s2_c_r);
    ed     = SW'(s2_d_r);
    mre    = SW'(ac_r) - SW'(bd_r);
    mim    = SW'(ad_r) + SW'(bc_r);
    nre    = SW'(ac_r) + SW'(bd_r);
    nim    = SW'(bc_r) - SW'(ad_r);
    den    = MW'($unsigned(cc_r)) + MW'($unsigned(dd_r));
    sq     = MW'($unsigned(aa_r)) + MW'($unsigned(bb_r));
    mag_re = nre[SW-1] ? MW'(-nre) : MW'(nre);
    mag_im = nim[SW-1] ? MW'(-nim) : MW'(nim);
    n_re   = NW'(mag_re) << FB;
    n_im   = NW'(mag_im) << FB;
    sr     = '0;
    si     = '0;
    case (s2_cmd_r)
      CMD_ADD: begin
        sr = sat_fn(ea + ec);
        si = sat_fn(eb + ed);
      end
      CMD_SUB: begin
        sr = sat_fn(ea - ec);
        si = sat_fn(eb - ed);
      end
      CMD_MUL: begin
        sr = sat_fn(mre >>> FB);
        si = sat_fn(mim >>> FB);
      end
      CMD_CONJ: begin
        sr.val = s2_a_r;
        sr.ov  = 1'b0;
        si     = sat_fn(-eb);
      end
      CMD_NEG: begin
        sr = sat_fn(-ea);
        si = sat_fn(-eb);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase

    cell_nxt.tag.cmd    = s2_cmd_r;
    cell_nxt.tag.rr     = sr.val;
    cell_nxt.tag.ri     = si.val;
    cell_nxt.tag.ov     = sr.ov | si.ov;
    cell_nxt.tag.dz     = (den == '0);
    cell_nxt.tag.neg_re = nre[SW-1];
    cell_nxt.tag.neg_im = nim[SW-1];
    cell_nxt.tag.pov_re = (n_re >> QW) >= NW'(den);
    cell_nxt.tag.pov_im = (n_im >> QW) >= NW'(den);
    cell_nxt.den        = den;
    cell_nxt.dre.rem    = MW'(n_re >> QW);
    cell_nxt.dre.nb     = n_re[QW-1:0];
    cell_nxt.dre.q      = '0;
    cell_nxt.dim.rem    = MW'(n_im >> QW);
    cell_nxt.dim.nb     = n_im[QW-1:0];
    cell_nxt.dim.q      = '0;
    cell_nxt.sq.rem     = '0;
    cell_nxt.sq.rad     = VW'(sq);
    cell_nxt.sq.root    = '0;
  end

  assign out_vld  = s3_vld_r;
  assign out_cell = cell_r;
endmodule
`default_nettype wire

FILE: verif/tb_complex_arithmetic_unit_core.sv
// Testbench for complex_arithmetic_unit_core: queued stimulus, in-bench predictor, result checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_complex_arithmetic_unit_core;
  import cau_pkg::*;

  localparam logic [2:0] CMD_RSVD = 3'd7;

  typedef struct {
    logic [2:0]           cmd;
    logic signed [DW-1:0] ar, ai, br, bi;
    int                   idle_pct;
  } op_t;

  typedef struct {
    logic signed [DW-1:0] rr, ri;
    logic                 dz, ov;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_command = '0;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid, out_div_zero, out_overflow;
  logic signed [DW-1:0] out_r_re, out_r_im;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0;

  complex_arithmetic_unit_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_r_re(out_r_re), .out_r_im(out_r_im),
    .out_div_zero(out_div_zero), .out_overflow(out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic signed [DW-1:0] clamp16(longint v, inout logic ov);
    if (v > 32767) begin
      ov = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ov = 1'b1;
      return 16'sh8000;
    end
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] quotient16(longint num, longint den,
                                                     inout logic ov);
    longint mag, q, lim;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    lim = (num < 0) ? 32768 : 32767;
    if (q > lim) begin
      ov = 1'b1;
      return (num < 0) ? 16'sh8000 : 16'sh7fff;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic res_t complex_result(op_t o);
    res_t   r;
    longint a, b, c, d, den, m;
    a = o.ar; b = o.ai; c = o.br; d = o.bi;
    r.rr = '0; r.ri = '0; r.dz = 1'b0; r.ov = 1'b0;
    case (o.cmd)
      CMD_ADD: begin
        r.rr = clamp16(a + c, r.ov);
        r.ri = clamp16(b + d, r.ov);
      end
      CMD_SUB: begin
        r.rr = clamp16(a - c, r.ov);
        r.ri = clamp16(b - d, r.ov);
      end
      CMD_MUL: begin
        r.rr = clamp16((a * c - b * d) >>> FB, r.ov);
        r.ri = clamp16((a * d + b * c) >>> FB, r.ov);
      end
      CMD_DIV: begin
        den = c * c + d * d;
        if (den == 0) r.dz = 1'b1;
        else begin
          r.rr = quotient16(a * c + b * d, den, r.ov);
          r.ri = quotient16(b * c - a * d, den, r.ov);
        end
      end
      CMD_CONJ: begin
        r.rr = o.ar;
        r.ri = clamp16(-b, r.ov);
      end
      CMD_NEG: begin
        r.rr = clamp16(-a, r.ov);
        r.ri = clamp16(-b, r.ov);
      end
      CMD_MAG: begin
        m = root_floor(a * a + b * b);
        r.rr = clamp16(m, r.ov);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(negedge clk) begin
    op_t o;
    if (rst_n && !(start && busy)) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= pending_ops[0].idle_pct) begin
        o = pending_ops.pop_front();
        in_command <= o.cmd;
        in_a_re <= o.ar; in_a_im <= o.ai; in_b_re <= o.br; in_b_im <= o.bi;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    op_t  o;
    res_t e;
    if (rst_n && start && !busy) begin
      o.cmd = in_command;
      o.ar = in_a_re; o.ai = in_a_im; o.br = in_b_re; o.bi = in_b_im;
      o.idle_pct = 0;
      expected_results.push_back(complex_result(o));
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction re=%0d im=%0d", $time, out_r_re, out_r_im);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_r_re !== e.rr || out_r_im !== e.ri || out_div_zero !== e.dz ||
            out_overflow !== e.ov) begin
          $display("%0t: mismatch expected re=%0d im=%0d dz=%b ov=%b", $time,
                   e.rr, e.ri, e.dz, e.ov);
          $display("%0t:          actual   re=%0d im=%0d dz=%b ov=%b", $time,
                   out_r_re, out_r_im, out_div_zero, out_overflow);
          errors++;
        end
      end
    end
  end

  task automatic queue_op(logic [2:0] cmd, logic signed [DW-1:0] ar, ai, br, bi, int pct);
    op_t o;
    o.cmd = cmd; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi; o.idle_pct = pct;
    pending_ops.push_back(o);
  endtask

  function automatic logic signed [DW-1:0] rand_val();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $urandom_range(0, 2047) - 1024;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  initial begin
    int pcts[4];
    pcts = '{0, 63, 0, 20};
    queue_op(CMD_ADD, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 0);
    queue_op(CMD_ADD, 16'sh1234, -16'sh0100, 16'sh0200, 16'sh0300, 0);
    queue_op(CMD_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 0);
    queue_op(CMD_MUL, 16'sh0100, 16'sh0200, -16'sh0180, 16'sh0080, 0);
    queue_op(CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    queue_op(CMD_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000, 0);
    queue_op(CMD_DIV, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_DIV, 16'sh0300, -16'sh0100, 16'sh0100, 16'sh0100, 0);
    queue_op(CMD_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000, 0);
    queue_op(CMD_DIV, -16'sh0007, 16'sh0005, 16'sh7fff, 16'sh8000, 0);
    queue_op(CMD_CONJ, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_CONJ, 16'sh7fff, 16'sh7fff, 16'shffff, 16'shffff, 0);
    queue_op(CMD_NEG, 16'sh8000, 16'sh0001, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_NEG, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_MAG, 16'sh0300, 16'sh0400, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_MAG, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 0);
    queue_op(CMD_MAG, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 0);
    queue_op(CMD_RSVD, 16'sh1234, 16'sh5678, 16'sh1111, 16'sh2222, 0);
    for (int p = 0; p < 4; p++)
      for (int i = 0; i < 235; i++)
        queue_op($urandom_range(0, 7), rand_val(), rand_val(), rand_val(), rand_val(),
                 pcts[p]);
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pending_ops.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
